// ----- src/dfr_pkg.sv -----
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types, constants, the CRC-16/MODBUS byte update and a saturating
// increment for the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int QUEUE_SLOTS     = 4;

	localparam logic [7:0]  END_BYTE_RST = 8'd10;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [15:0] CNT_MAX      = 16'hFFFF;

	typedef enum logic [1:0] {
		K_BYTE  = 2'd0,
		K_POP   = 2'd1,
		K_CLEAR = 2'd2,
		K_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_CRC_ERR  = 3'd2,
		ST_FMT_ERR  = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic rd_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic pop_go;
		logic last_byte;
	} dp_sts_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage

// ----- src/delimited_frame_receiver_crc16_queue_core.sv -----
// ----------------------------------------------------------------------------
// delimited_frame_receiver_crc16_queue_core
// Delimited frame receiver with CRC-16/MODBUS check and a frame queue.
// ----------------------------------------------------------------------------
// channel  signals                      role
// in       in_valid/in_stall, kind...   byte, pop or clear transaction
// out      out_valid/out_stall, status.. result transactions, in order
// cfg      cfg_we/cfg_data              end byte register write
//
// Byte, clear, empty pop and empty-payload pop transactions give one result
// each.
// A pop of n payload bytes gives n results: after the accept, each byte
// takes a memory read, then a result register load that out_stall can hold.
// A new input transaction is taken when idle and the result register is free
// or being taken; out_stall holds the block. No clearing pass after reset.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_crc16_queue_core #(
	parameter int MAXB = dfr_pkg::MAX_FRAME_BYTES,
	parameter int QS   = dfr_pkg::QUEUE_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  data_byte,
	output logic        byte_valid,
	output logic        last,
	output logic [5:0]  frame_len,
	output logic [15:0] frame_crc,
	output logic [2:0]  frames_queued,
	output logic [6:0]  fill_index,
	output logic [15:0] ovf_events,
	output logic [15:0] crc_bad_events,
	output logic [15:0] runt_events,
	output logic [15:0] good_frames
);

	dfr_pkg::dp_cmd_t cmd;
	dfr_pkg::dp_sts_t sts;

	dfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dfr_dpath #(
		.MAXB (MAXB),
		.QS   (QS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.last           (last),
		.frame_len      (frame_len),
		.frame_crc      (frame_crc),
		.frames_queued  (frames_queued),
		.fill_index     (fill_index),
		.ovf_events     (ovf_events),
		.crc_bad_events (crc_bad_events),
		.runt_events    (runt_events),
		.good_frames    (good_frames)
	);

	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (!out_valid || !out_stall))
		else $error("input taken while result register blocked");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && kind != dfr_pkg::K_POP) |=> out_valid)
		else $error("no result after non-pop transaction");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_valid) |-> (status == dfr_pkg::ST_OK && frame_len != 6'd0))
		else $error("payload byte with bad status or length");

endmodule

// ----- src/dfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dfr_ctrl
// Sequencer: takes input transactions when idle, then walks the payload
// read-out of a popped frame one byte per result.
// ----------------------------------------------------------------------------
module dfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dfr_pkg::dp_sts_t  sts,
	output dfr_pkg::dp_cmd_t  cmd
);

	dfr_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfr_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		in_stall    = 1'b1;
		cmd.accept  = 1'b0;
		cmd.rd_load = 1'b0;
		case (state_q)
			dfr_pkg::S_IDLE: begin
				in_stall   = !sts.out_free;
				cmd.accept = in_valid && sts.out_free;
				if (cmd.accept && sts.pop_go) begin
					state_nxt = dfr_pkg::S_READ;
				end
			end
			dfr_pkg::S_READ: begin
				state_nxt = dfr_pkg::S_EMIT;
			end
			dfr_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.rd_load = 1'b1;
					state_nxt   = sts.last_byte ? dfr_pkg::S_IDLE : dfr_pkg::S_READ;
				end
			end
			default: begin
				state_nxt = dfr_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/dfr_dpath.sv -----
// ----------------------------------------------------------------------------
// dfr_dpath
// Frame assembly with running CRC, slot memory, queue pointers, event
// counters and the result register.
// ----------------------------------------------------------------------------
module dfr_dpath #(
	parameter int MAXB = dfr_pkg::MAX_FRAME_BYTES,
	parameter int QS   = dfr_pkg::QUEUE_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dfr_pkg::dp_cmd_t  cmd,
	output dfr_pkg::dp_sts_t  sts,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	input  logic [1:0]        kind,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [7:0]        data_byte,
	output logic              byte_valid,
	output logic              last,
	output logic [5:0]        frame_len,
	output logic [15:0]       frame_crc,
	output logic [2:0]        frames_queued,
	output logic [6:0]        fill_index,
	output logic [15:0]       ovf_events,
	output logic [15:0]       crc_bad_events,
	output logic [15:0]       runt_events,
	output logic [15:0]       good_frames
);

	// one spare physical slot so assembly never overwrites a queued frame
	localparam int PS   = QS + 1;
	localparam int PW   = $clog2(PS);
	localparam int IW   = $clog2(MAXB);
	localparam int CNTW = $clog2(MAXB + 1);
	localparam int OW   = $clog2(QS + 1);
	localparam int MD   = PS * (2 ** IW);

	logic [7:0]      end_byte_q;
	logic [CNTW-1:0] cnt_q, cnt_nxt;
	logic            disc_q, disc_nxt;
	logic [15:0]     crc_q, crc_d1_q, crc_d2_q;
	logic [15:0]     crc_nxt, crc_d1_nxt, crc_d2_nxt;
	logic [7:0]      p1_q, p2_q, p1_nxt, p2_nxt;
	logic [PW-1:0]   rp_q, wp_q, rp_nxt, wp_nxt;
	logic [OW-1:0]   occ_q, occ_nxt;
	logic [15:0]     ovf_q, crce_q, fmt_q, tot_q;
	logic [15:0]     ovf_nxt, crce_nxt, fmt_nxt, tot_nxt;
	logic [IW-1:0]   len_mem [PS];
	logic [15:0]     crc_mem [PS];
	logic [7:0]      pay_mem [MD];
	logic [7:0]      rdata_q;
	logic [PW-1:0]   pslot_q;
	logic [IW-1:0]   plen_q, idx_q;
	logic [15:0]     pcrc_q;

	logic            mem_we, push, pop, frame_rst;
	logic [IW-1:0]   new_len;
	logic [2:0]      res_status;
	logic            res_load;
	logic [IW-1:0]   res_len;
	logic [15:0]     res_crc;
	logic            is_byte, is_pop, is_clear;
	logic            vld_q;

	assign is_byte  = cmd.accept && (kind == dfr_pkg::K_BYTE);
	assign is_pop   = cmd.accept && (kind == dfr_pkg::K_POP);
	assign is_clear = cmd.accept && (kind == dfr_pkg::K_CLEAR);

	always_comb begin
		cnt_nxt    = cnt_q;
		disc_nxt   = disc_q;
		crc_nxt    = crc_q;
		crc_d1_nxt = crc_d1_q;
		crc_d2_nxt = crc_d2_q;
		p1_nxt     = p1_q;
		p2_nxt     = p2_q;
		rp_nxt     = rp_q;
		wp_nxt     = wp_q;
		occ_nxt    = occ_q;
		ovf_nxt    = ovf_q;
		crce_nxt   = crce_q;
		fmt_nxt    = fmt_q;
		tot_nxt    = tot_q;
		mem_we     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		frame_rst  = 1'b0;
		new_len    = IW'(cnt_q - CNTW'(2));
		res_status = dfr_pkg::ST_OK;
		res_load   = cmd.accept;
		res_len    = '0;
		res_crc    = '0;
		if (is_byte) begin
			if (disc_q) begin
				if (rx_byte == end_byte_q) begin
					disc_nxt = 1'b0;
				end
			end else if (cnt_q >= CNTW'(MAXB)) begin
				ovf_nxt    = dfr_pkg::sat_inc(ovf_q);
				disc_nxt   = 1'b1;
				frame_rst  = 1'b1;
				res_status = dfr_pkg::ST_OVERFLOW;
			end else begin
				mem_we = 1'b1;
				if (rx_byte == end_byte_q) begin
					frame_rst = 1'b1;
					if (cnt_q < CNTW'(2)) begin
						fmt_nxt    = dfr_pkg::sat_inc(fmt_q);
						res_status = dfr_pkg::ST_FMT_ERR;
					end else if ({p1_q, p2_q} != crc_d2_q) begin
						crce_nxt   = dfr_pkg::sat_inc(crce_q);
						res_status = dfr_pkg::ST_CRC_ERR;
					end else if (occ_q >= OW'(QS)) begin
						ovf_nxt    = dfr_pkg::sat_inc(ovf_q);
						res_status = dfr_pkg::ST_OVERFLOW;
					end else begin
						push    = 1'b1;
						wp_nxt  = (wp_q == PW'(PS - 1)) ? '0 : wp_q + PW'(1);
						occ_nxt = occ_q + OW'(1);
						tot_nxt = dfr_pkg::sat_inc(tot_q);
					end
				end else begin
					cnt_nxt    = cnt_q + CNTW'(1);
					crc_nxt    = dfr_pkg::crc16_byte(crc_q, rx_byte);
					crc_d1_nxt = crc_q;
					crc_d2_nxt = crc_d1_q;
					p1_nxt     = rx_byte;
					p2_nxt     = p1_q;
				end
			end
		end else if (is_pop) begin
			if (occ_q == '0) begin
				res_status = dfr_pkg::ST_EMPTY;
			end else begin
				pop     = 1'b1;
				rp_nxt  = (rp_q == PW'(PS - 1)) ? '0 : rp_q + PW'(1);
				occ_nxt = occ_q - OW'(1);
				res_crc = crc_mem[rp_q];
				if (len_mem[rp_q] != '0) begin
					res_load = 1'b0;
				end
			end
		end else if (is_clear) begin
			frame_rst = 1'b1;
			disc_nxt  = 1'b0;
			rp_nxt    = '0;
			wp_nxt    = '0;
			occ_nxt   = '0;
		end
		if (frame_rst) begin
			cnt_nxt    = '0;
			crc_nxt    = dfr_pkg::CRC_INIT;
			crc_d1_nxt = dfr_pkg::CRC_INIT;
			crc_d2_nxt = dfr_pkg::CRC_INIT;
		end
		if (cmd.rd_load) begin
			res_load = 1'b1;
			res_len  = plen_q;
			res_crc  = pcrc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_byte_q <= dfr_pkg::END_BYTE_RST;
			cnt_q      <= '0;
			disc_q     <= 1'b0;
			crc_q      <= dfr_pkg::CRC_INIT;
			crc_d1_q   <= dfr_pkg::CRC_INIT;
			crc_d2_q   <= dfr_pkg::CRC_INIT;
			p1_q       <= '0;
			p2_q       <= '0;
			rp_q       <= '0;
			wp_q       <= '0;
			occ_q      <= '0;
			ovf_q      <= '0;
			crce_q     <= '0;
			fmt_q      <= '0;
			tot_q      <= '0;
			vld_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				end_byte_q <= cfg_data;
			end
			cnt_q    <= cnt_nxt;
			disc_q   <= disc_nxt;
			crc_q    <= crc_nxt;
			crc_d1_q <= crc_d1_nxt;
			crc_d2_q <= crc_d2_nxt;
			p1_q     <= p1_nxt;
			p2_q     <= p2_nxt;
			rp_q     <= rp_nxt;
			wp_q     <= wp_nxt;
			occ_q    <= occ_nxt;
			ovf_q    <= ovf_nxt;
			crce_q   <= crce_nxt;
			fmt_q    <= fmt_nxt;
			tot_q    <= tot_nxt;
			if (res_load) begin
				vld_q <= 1'b1;
			end else if (!out_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	// payload memory and slot descriptors
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pay_mem[{wp_q, cnt_q[IW-1:0]}] <= rx_byte;
		end
		rdata_q <= pay_mem[{pslot_q, idx_q}];
		if (push) begin
			len_mem[wp_q] <= new_len;
			crc_mem[wp_q] <= crc_d2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pslot_q <= rp_q;
			plen_q  <= len_mem[rp_q];
			pcrc_q  <= crc_mem[rp_q];
			idx_q   <= '0;
		end else if (cmd.rd_load) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			status         <= res_status;
			data_byte      <= cmd.rd_load ? rdata_q : 8'h00;
			byte_valid     <= cmd.rd_load;
			last           <= cmd.rd_load ? sts.last_byte : 1'b1;
			frame_len      <= 6'(res_len);
			frame_crc      <= res_crc;
			frames_queued  <= 3'(occ_nxt);
			fill_index     <= 7'(cnt_nxt);
			ovf_events     <= ovf_nxt;
			crc_bad_events <= crce_nxt;
			runt_events    <= fmt_nxt;
			good_frames    <= tot_nxt;
		end
	end

	assign out_valid     = vld_q;
	assign sts.out_free  = !vld_q || !out_stall;
	assign sts.pop_go    = is_pop && (occ_q != '0) && (len_mem[rp_q] != '0);
	assign sts.last_byte = (idx_q == plen_q - IW'(1));

endmodule
